// ===== design/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// shared types, constants and command/status bundles for the sha-1 digest block
// ----------------------------------------------------------------------------
package sha1md_pkg;

	localparam int WordW  = 32;
	localparam int ByteW  = 8;
	localparam int TotalW = 61;
	localparam int LenW   = 64;
	localparam int PosW   = 6;
	localparam int RndW   = 7;
	localparam int IdxW   = 3;
	localparam int CfgIdxW = 2;
	localparam int NumChain = 5;
	localparam int NumSched = 16;

	localparam logic [RndW-1:0] RndLast  = 7'd79;
	localparam logic [RndW-1:0] RndSched = 7'd16;
	localparam logic [RndW-1:0] RndPhB   = 7'd20;
	localparam logic [RndW-1:0] RndPhC   = 7'd40;
	localparam logic [RndW-1:0] RndPhD   = 7'd60;
	localparam logic [PosW-1:0] PosLast  = 6'd63;
	localparam logic [PosW-1:0] PosLenM1 = 6'd55;
	localparam logic [IdxW-1:0] IdxLast  = 3'd4;
	localparam logic [ByteW-1:0] PadMark = 8'h80;

	localparam logic [WordW-1:0] InitH0 = 32'h67452301;
	localparam logic [WordW-1:0] InitH1 = 32'hEFCDAB89;
	localparam logic [WordW-1:0] InitH2 = 32'h98BADCFE;
	localparam logic [WordW-1:0] InitH3 = 32'h10325476;
	localparam logic [WordW-1:0] InitH4 = 32'hC3D2E1F0;

	localparam logic [WordW-1:0] RstKa = 32'h5A827999;
	localparam logic [WordW-1:0] RstKb = 32'h6ED9EBA1;
	localparam logic [WordW-1:0] RstKc = 32'h8F1BBCDC;
	localparam logic [WordW-1:0] RstKd = 32'hCA62C1D6;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegKa = 2'd0;
	localparam logic [CfgIdxW-1:0] RegKb = 2'd1;
	localparam logic [CfgIdxW-1:0] RegKc = 2'd2;
	localparam logic [CfgIdxW-1:0] RegKd = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_ADD,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_DONE
	} state_t;

	// where to go once a compression has been folded into the chain
	typedef enum logic [1:0] {
		RET_IDLE,
		RET_MARK,
		RET_ZERO,
		RET_DONE
	} ret_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} src_t;

	typedef struct packed {
		logic pk_en;
		src_t pk_src;
		logic cnt_en;
		logic len_load;
		logic len_shift;
		logic rnd_init;
		logic rnd_en;
		logic chain_add;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pos_len_m1;
		logic rnd_last;
		logic out_busy;
	} sts_t;

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int n);
		rotl = (v << n) | (v >> (WordW - n));
	endfunction

endpackage

// ===== design/sha1md_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1md_ctrl
// sequencer: byte intake, padding, compression and digest hand-off
// ----------------------------------------------------------------------------
module sha1md_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic             s_axis_tuser,
	input  logic             s_axis_tlast,
	input  sha1md_pkg::sts_t sts,
	output sha1md_pkg::cmd_t cmd
);
	import sha1md_pkg::*;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;
	logic   take;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (s_axis_tuser && sts.pos_last) begin
						state_d = ST_COMP;
						ret_d   = s_axis_tlast ? RET_MARK : RET_IDLE;
					end else if (s_axis_tlast) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_COMP: begin
				if (sts.rnd_last) state_d = ST_ADD;
			end
			ST_ADD: begin
				unique case (ret_q)
					RET_IDLE: state_d = ST_IDLE;
					RET_MARK: state_d = ST_PAD_MARK;
					RET_ZERO: state_d = ST_PAD_ZERO;
					RET_DONE: state_d = ST_DONE;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_PAD_MARK, ST_PAD_ZERO: begin
				if (sts.pos_last) begin
					state_d = ST_COMP;
					ret_d   = RET_ZERO;
				end else if (sts.pos_len_m1) begin
					state_d = ST_PAD_LEN;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_LEN: begin
				if (sts.pos_last) begin
					state_d = ST_COMP;
					ret_d   = RET_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.pk_src = SRC_IN;
		unique case (state_q)
			ST_IDLE: begin
				if (take && s_axis_tuser) begin
					cmd.pk_en    = 1'b1;
					cmd.cnt_en   = 1'b1;
					cmd.rnd_init = sts.pos_last;
				end
			end
			ST_COMP:  cmd.rnd_en = 1'b1;
			ST_ADD:   cmd.chain_add = 1'b1;
			ST_PAD_MARK: begin
				cmd.pk_en    = 1'b1;
				cmd.pk_src   = SRC_MARK;
				cmd.len_load = 1'b1;
				cmd.rnd_init = sts.pos_last;
			end
			ST_PAD_ZERO: begin
				cmd.pk_en    = 1'b1;
				cmd.pk_src   = SRC_ZERO;
				cmd.rnd_init = sts.pos_last;
			end
			ST_PAD_LEN: begin
				cmd.pk_en     = 1'b1;
				cmd.pk_src    = SRC_LEN;
				cmd.len_shift = 1'b1;
				cmd.rnd_init  = sts.pos_last;
			end
			ST_DONE:  cmd.out_load = !sts.out_busy;
			default:  cmd = '0;
		endcase
	end

endmodule

// ===== design/sha1md_dp.sv =====
// ----------------------------------------------------------------------------
// sha1md_dp
// datapath: byte packer, schedule shift line, round unit, chain and digest buffer
// ----------------------------------------------------------------------------
module sha1md_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sha1md_pkg::cmd_t                     cmd,
	output sha1md_pkg::sts_t                     sts,
	input  logic [sha1md_pkg::ByteW-1:0]         in_byte,
	input  logic                                 cfg_we,
	input  logic [sha1md_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [sha1md_pkg::WordW-1:0]         cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sha1md_pkg::WordW-1:0]         out_word,
	output logic [sha1md_pkg::IdxW-1:0]          out_idx,
	output logic                                 out_last
);
	import sha1md_pkg::*;

	logic [WordW-1:0]  k_q [4];
	logic [WordW-1:0]  sched_q [NumSched];
	logic [WordW-1:0]  chain_q [NumChain];
	logic [WordW-1:0]  work_q [NumChain];
	logic [WordW-1:0]  dig_q [NumChain];
	logic [WordW-1:0]  acc_q;
	logic [PosW-1:0]   pos_q;
	logic [TotalW-1:0] total_q;
	logic [LenW-1:0]   len_q;
	logic [RndW-1:0]   rnd_q;
	logic [IdxW-1:0]   oidx_q;
	logic              busy_q;

	logic [ByteW-1:0]  pk_byte;
	logic [WordW-1:0]  pk_word;
	logic [WordW-1:0]  w_new, f_val, k_val, t_sum;
	logic              out_take;

	always_comb begin
		case (cmd.pk_src)
			SRC_IN:   pk_byte = in_byte;
			SRC_MARK: pk_byte = PadMark;
			SRC_ZERO: pk_byte = '0;
			SRC_LEN:  pk_byte = len_q[LenW-1 -: ByteW];
			default:  pk_byte = '0;
		endcase
	end
	assign pk_word = {acc_q[WordW-ByteW-1:0], pk_byte};

	// schedule taps: oldest word sits at index 0
	always_comb begin
		if (rnd_q < RndSched) begin
			w_new = sched_q[0];
		end else begin
			w_new = rotl(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1);
		end
	end

	always_comb begin
		if (rnd_q < RndPhB) begin
			f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
			k_val = k_q[0];
		end else if (rnd_q < RndPhC) begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = k_q[1];
		end else if (rnd_q < RndPhD) begin
			f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
				(work_q[2] & work_q[3]);
			k_val = k_q[2];
		end else begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = k_q[3];
		end
	end
	assign t_sum = rotl(work_q[0], 5) + f_val + work_q[4] + k_val + w_new;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q[0] <= RstKa;
			k_q[1] <= RstKb;
			k_q[2] <= RstKc;
			k_q[3] <= RstKd;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegKa: k_q[0] <= cfg_data;
				RegKb: k_q[1] <= cfg_data;
				RegKc: k_q[2] <= cfg_data;
				RegKd: k_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// packer, schedule line, length register and digest buffer, no reset: every word is filled before use
	always_ff @(posedge clk) begin
		if (cmd.pk_en) begin
			acc_q <= pk_word;
			if (pos_q[1:0] == 2'b11) begin
				for (int i = 0; i < NumSched - 1; i++) sched_q[i] <= sched_q[i+1];
				sched_q[NumSched-1] <= pk_word;
			end
		end else if (cmd.rnd_en) begin
			for (int i = 0; i < NumSched - 1; i++) sched_q[i] <= sched_q[i+1];
			sched_q[NumSched-1] <= w_new;
		end
		if (cmd.len_load) begin
			len_q <= {total_q, 3'b000};
		end else if (cmd.len_shift) begin
			len_q <= {len_q[LenW-ByteW-1:0], {ByteW{1'b0}}};
		end
		if (cmd.out_load) begin
			for (int i = 0; i < NumChain; i++) dig_q[i] <= chain_q[i];
		end else if (out_take) begin
			for (int i = 0; i < NumChain - 1; i++) dig_q[i] <= dig_q[i+1];
			dig_q[NumChain-1] <= dig_q[NumChain-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			total_q <= '0;
			rnd_q   <= '0;
		end else begin
			if (cmd.pk_en) pos_q <= pos_q + 1'b1;
			if (cmd.len_load) begin
				total_q <= '0;
			end else if (cmd.cnt_en) begin
				total_q <= total_q + 1'b1;
			end
			if (cmd.rnd_init) begin
				rnd_q <= '0;
			end else if (cmd.rnd_en) begin
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	// round registers and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumChain; i++) work_q[i] <= '0;
			chain_q[0] <= InitH0;
			chain_q[1] <= InitH1;
			chain_q[2] <= InitH2;
			chain_q[3] <= InitH3;
			chain_q[4] <= InitH4;
		end else begin
			if (cmd.rnd_init) begin
				for (int i = 0; i < NumChain; i++) work_q[i] <= chain_q[i];
			end else if (cmd.rnd_en) begin
				work_q[0] <= t_sum;
				work_q[1] <= work_q[0];
				work_q[2] <= rotl(work_q[1], 30);
				work_q[3] <= work_q[2];
				work_q[4] <= work_q[3];
			end
			if (cmd.chain_add) begin
				for (int i = 0; i < NumChain; i++) chain_q[i] <= chain_q[i] + work_q[i];
			end else if (cmd.out_load) begin
				chain_q[0] <= InitH0;
				chain_q[1] <= InitH1;
				chain_q[2] <= InitH2;
				chain_q[3] <= InitH3;
				chain_q[4] <= InitH4;
			end
		end
	end

	// digest output buffer
	assign out_take = busy_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			oidx_q <= '0;
		end else if (cmd.out_load) begin
			busy_q <= 1'b1;
			oidx_q <= '0;
		end else if (out_take) begin
			oidx_q <= oidx_q + 1'b1;
			if (oidx_q == IdxLast) busy_q <= 1'b0;
		end
	end

	assign out_valid = busy_q;
	assign out_word  = dig_q[0];
	assign out_idx   = oidx_q;
	assign out_last  = (oidx_q == IdxLast);

	assign sts.pos_last   = (pos_q == PosLast);
	assign sts.pos_len_m1 = (pos_q == PosLenM1);
	assign sts.rnd_last   = (rnd_q == RndLast);
	assign sts.out_busy   = busy_q;

endmodule

// ===== design/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest
// byte-stream sha-1 engine with hardware padding and configurable round constants
// ----------------------------------------------------------------------------
// Message bytes come in one beat at a time on the slave stream (tuser = byte
// present, tlast = end of message) and are packed big-endian into 512-bit
// blocks. A byte beat is taken every cycle while the packer is filling; the
// beat that completes a block starts one shared round unit that runs the 80
// rounds at one per cycle and then folds the result into the chaining words;
// the slave side holds tready low during this compression. At the end of a
// message the padding (0x80, zeros, 64-bit bit length) is fed through the same
// byte packer one byte per cycle, pausing while a full block is compressed, and
// takes one or two compressions; the five digest words then leave on the master
// stream, word 0 first, as 5 beats. The digest sits in its own buffer, so the
// next message can start while the words drain; a finished digest waits only if
// the previous one is still unread. Round constants are written through the cfg
// port; the user must write them only while idle, as the block has no guard.
// ----------------------------------------------------------------------------
module sha1_message_digest (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // [7:0] msg_byte
	input  logic                              s_axis_tuser,   // [0] byte_present
	input  logic                              s_axis_tlast,   // msg_end
	// master stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [39:0]                       m_axis_tdata,   // [31:0] digest_word,
	                                                          // [34:32] word_index
	output logic                              m_axis_tlast,   // digest_last
	// configuration writes
	input  logic                              cfg_we,
	input  logic [sha1md_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [sha1md_pkg::WordW-1:0]      cfg_data
);
	import sha1md_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [WordW-1:0] out_word;
	logic [IdxW-1:0]  out_idx;

	// sequencer
	sha1md_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.sts           (sts),
		.cmd           (cmd)
	);

	// packer, rounds, chain and digest buffer
	sha1md_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word),
		.out_idx   (out_idx),
		.out_last  (m_axis_tlast)
	);

	// upper bits pad the beat to whole bytes
	assign m_axis_tdata = {5'b00000, out_idx, out_word};

endmodule

// ===== design/sha1md_chk.sv =====
// ----------------------------------------------------------------------------
// sha1md_chk
// port-level checks for the sha-1 digest block, bound to the top level
// ----------------------------------------------------------------------------
module sha1md_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled digest beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("digest beat changed while stalled");

	// word index steps by one through a digest
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && (m_axis_tdata[34:32] == 3'($past(m_axis_tdata[34:32]) + 3'd1)))
		else $error("digest word index did not advance");

	// last flag marks word four only
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd4)))
		else $error("digest last flag out of place");

	// no second digest right behind the first
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("digest started without a compression");

	// end of message stops intake for padding
	a_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken during padding");

endmodule

bind sha1_message_digest sha1md_chk u_sha1md_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
